// File: hdl/ispm_pkg.sv
// shared types and constants of the i2c slave packet mailbox
package ispm_pkg;

  localparam int unsigned PacketBytesDef = 256;
  localparam int unsigned RxSlotsDef     = 4;
  localparam int unsigned TxSlotsDef     = 4;
  localparam int unsigned CmdDepth       = 2;
  localparam int unsigned OutDepth       = 3;

  typedef enum logic [2:0] {
    MODE_ADDR = 3'd0,
    MODE_RX   = 3'd1,
    MODE_STOP = 3'd2,
    MODE_REQ  = 3'd3,
    MODE_ERR  = 3'd4,
    MODE_LOAD = 3'd5,
    MODE_HOST = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RX_FULL = 3'd1,
    ST_TX_FULL = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_READ = 4'b1000
  } phase_e;

  localparam logic [7:0] CMD_LEN  = 8'd0;
  localparam logic [7:0] CMD_DATA = 8'd1;
  localparam logic [7:0] BYTE_LIMIT = 8'd255;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } ispm_in_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       bus_byte_loaded;
    logic [7:0] host_byte;
    logic       host_byte_valid;
    logic       host_byte_last;
    logic       packet_committed;
    logic [2:0] status;
  } ispm_out_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } ispm_cmd_t;

endpackage

// File: hdl/ispm_fifo.sv
// small register queue used between the stages
module ispm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [LW-1:0]    lvl_q, lvl_d;
  logic             do_push, do_pop;

  assign full_o  = (lvl_q == LW'(DEPTH));
  assign empty_o = (lvl_q == '0);
  assign level_o = lvl_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    lvl_d = lvl_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + LW'(1);
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hdl/ispm_front.sv
// front end: takes requests, decodes the event kind and queues them
module ispm_front import ispm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  ispm_in_t  in_i,
  output logic      cmd_valid_o,
  output ispm_cmd_t cmd_o,
  input  logic      cmd_pop_i
);

  ispm_cmd_t                     dec;
  logic                          q_empty;
  logic [$clog2(CmdDepth+1)-1:0] q_level;

  always_comb begin
    dec.mode      = mode_e'(in_i.mode);
    dec.data_byte = in_i.data_byte;
    // last flag only means something for host loads
    dec.last_byte = (in_i.mode == MODE_LOAD) ? in_i.last_byte : 1'b0;
  end

  ispm_fifo #(
    .WIDTH($bits(ispm_cmd_t)),
    .DEPTH(CmdDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (dec),
    .full_o (full),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .empty_o(q_empty),
    .level_o(q_level)
  );

  assign cmd_valid_o = !q_empty && (q_level != '0);

endmodule

// File: hdl/ispm_back.sv
// back end: bus phase, packet queues and packet memories
module ispm_back import ispm_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PacketBytesDef,
  parameter int unsigned RX_SLOTS     = RxSlotsDef,
  parameter int unsigned TX_SLOTS     = TxSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  ispm_cmd_t                     cmd_i,
  output logic                          cmd_pop_o,
  input  logic [$clog2(OutDepth+1)-1:0] out_level_i,
  output logic                          res_valid_o,
  output ispm_out_t                     res_o
);

  // rx buffers rotate: the tail position is the staging buffer
  localparam int unsigned RXP = RX_SLOTS + 1;
  localparam int unsigned RPW = $clog2(RXP);
  localparam int unsigned TPW = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
  localparam int unsigned RCW = $clog2(RX_SLOTS + 1);
  localparam int unsigned TCW = $clog2(TX_SLOTS + 1);
  localparam int unsigned RAW = $clog2(RXP * PACKET_BYTES);
  localparam int unsigned TAW = $clog2(TX_SLOTS * PACKET_BYTES);
  localparam int unsigned OLW = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    HS_KEEP = 2'd0,
    HS_ZERO = 2'd1,
    HS_LEN  = 2'd2,
    HS_MEM  = 2'd3
  } held_sel_e;

  typedef struct packed {
    held_sel_e  sel;
    logic [7:0] len;
    logic       loaded;
    logic       hvalid;
    logic       hlast;
    logic       committed;
    status_e    status;
  } stage_t;

  phase_e          phase_q, phase_d;
  logic [7:0]      cmd_q, cmd_d, exp_q, exp_d, fill_q, fill_d;
  logic [7:0]      rd_idx_q, rd_idx_d, send_q, send_d, load_q, load_d;
  logic [7:0]      held_q, held_new;
  logic [RPW-1:0]  rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RCW-1:0]  rx_cnt_q, rx_cnt_d;
  logic [TPW-1:0]  tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TCW-1:0]  tx_cnt_q, tx_cnt_d;
  logic [7:0]      rx_len_q [RXP];
  logic [7:0]      tx_len_q [TX_SLOTS];
  logic [7:0]      rx_mem [RXP * PACKET_BYTES];
  logic [7:0]      tx_mem [TX_SLOTS * PACKET_BYTES];
  logic [7:0]      rx_rdata_q, tx_rdata_q;

  logic            go;
  logic            rx_we, rx_re, tx_we, tx_re, rx_len_we, tx_len_we;
  logic [RAW-1:0]  rx_waddr, rx_raddr;
  logic [TAW-1:0]  tx_waddr, tx_raddr;
  logic [7:0]      tx_len_val, load_next, cur_len;
  logic            b_valid_q;
  stage_t          b_q, b_d;

  function automatic logic idx_fits(logic [7:0] idx);
    return (idx != BYTE_LIMIT) && ({1'b0, idx} < 9'(PACKET_BYTES));
  endfunction

  function automatic logic [RPW-1:0] rx_inc(logic [RPW-1:0] p);
    return (p == RPW'(RXP - 1)) ? '0 : p + RPW'(1);
  endfunction

  function automatic logic [TPW-1:0] tx_inc(logic [TPW-1:0] p);
    return (p == TPW'(TX_SLOTS - 1)) ? '0 : p + TPW'(1);
  endfunction

  // room for the request in flight plus this one in the result queue
  assign go = cmd_valid_i &&
              (({1'b0, out_level_i} + (OLW+1)'(b_valid_q)) < (OLW+1)'(OutDepth));
  assign cmd_pop_o = go;

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    exp_d     = exp_q;
    fill_d    = fill_q;
    rd_idx_d  = rd_idx_q;
    send_d    = send_q;
    load_d    = load_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    tx_cnt_d  = tx_cnt_q;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    rx_len_we = 1'b0;
    tx_len_we = 1'b0;
    rx_waddr  = RAW'(rx_tail_q) * RAW'(PACKET_BYTES) + RAW'(fill_q);
    rx_raddr  = RAW'(rx_head_q) * RAW'(PACKET_BYTES) + RAW'(rd_idx_q);
    tx_waddr  = TAW'(tx_tail_q) * TAW'(PACKET_BYTES) + TAW'(load_q);
    tx_raddr  = TAW'(tx_head_q) * TAW'(PACKET_BYTES) + TAW'(send_q);
    load_next = load_q + 8'd1;
    tx_len_val = load_q;
    cur_len   = rx_len_q[rx_head_q];
    b_d       = '{sel: HS_KEEP, len: tx_len_q[tx_head_q], loaded: 1'b0, hvalid: 1'b0,
                  hlast: 1'b0, committed: 1'b0, status: ST_OK};
    if (go) begin
      case (cmd_i.mode)
        MODE_ADDR: begin
          phase_d = PH_CMD;
        end
        MODE_RX: begin
          if (phase_q == PH_CMD) begin
            cmd_d   = cmd_i.data_byte;
            phase_d = PH_DATA;
          end else begin
            if (cmd_q == CMD_LEN) begin
              exp_d  = cmd_i.data_byte;
              fill_d = '0;
            end else if (cmd_q == CMD_DATA) begin
              if (idx_fits(fill_q)) begin
                rx_we  = 1'b1;
                fill_d = fill_q + 8'd1;
              end else begin
                b_d.status = ST_RANGE;
              end
            end
            phase_d = PH_READ;
          end
        end
        MODE_STOP: begin
          if (phase_q == PH_READ) begin
            phase_d = PH_CMD;
            if (fill_q == exp_q) begin
              fill_d = '0;
              if (rx_cnt_q < RCW'(RX_SLOTS)) begin
                rx_len_we     = 1'b1;
                rx_tail_d     = rx_inc(rx_tail_q);
                rx_cnt_d      = rx_cnt_q + RCW'(1);
                b_d.committed = 1'b1;
              end else begin
                b_d.status = ST_RX_FULL;
              end
            end
          end
        end
        MODE_REQ: begin
          if (phase_q == PH_DATA) begin
            if ((cmd_q == CMD_LEN) || (cmd_q == CMD_DATA)) begin
              b_d.loaded = 1'b1;
              if (tx_cnt_q == '0) begin
                b_d.sel = HS_ZERO;
              end else if (cmd_q == CMD_LEN) begin
                send_d  = '0;
                b_d.sel = HS_LEN;
              end else begin
                if ({1'b0, send_q} < 9'(PACKET_BYTES)) begin
                  tx_re   = 1'b1;
                  b_d.sel = HS_MEM;
                end else begin
                  b_d.sel = HS_ZERO;
                end
                if (({1'b0, send_q} + 9'd1) >= {1'b0, tx_len_q[tx_head_q]}) begin
                  tx_head_d = tx_inc(tx_head_q);
                  tx_cnt_d  = tx_cnt_q - TCW'(1);
                  send_d    = '0;
                end else begin
                  send_d = send_q + 8'd1;
                end
              end
            end
            phase_d = PH_CMD;
          end
        end
        MODE_LOAD: begin
          if (tx_cnt_q >= TCW'(TX_SLOTS)) begin
            b_d.status = ST_TX_FULL;
          end else begin
            if (idx_fits(load_q)) begin
              tx_we      = 1'b1;
              tx_len_val = load_next;
              load_d     = load_next;
            end else begin
              b_d.status = ST_RANGE;
            end
            if (cmd_i.last_byte) begin
              tx_len_we = 1'b1;
              tx_tail_d = tx_inc(tx_tail_q);
              tx_cnt_d  = tx_cnt_q + TCW'(1);
              load_d    = '0;
            end
          end
        end
        MODE_HOST: begin
          if (rx_cnt_q == '0) begin
            b_d.status = ST_EMPTY;
          end else begin
            if ((cur_len != '0) && ({1'b0, rd_idx_q} < 9'(PACKET_BYTES))) begin
              rx_re      = 1'b1;
              b_d.hvalid = 1'b1;
            end
            if (({1'b0, rd_idx_q} + 9'd1) >= {1'b0, cur_len}) begin
              b_d.hlast = 1'b1;
              rx_head_d = rx_inc(rx_head_q);
              rx_cnt_d  = rx_cnt_q - RCW'(1);
              rd_idx_d  = '0;
            end else begin
              rd_idx_d = rd_idx_q + 8'd1;
            end
          end
        end
        default: begin
          phase_d = PH_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cmd_q     <= '0;
      exp_q     <= '0;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      send_q    <= '0;
      load_q    <= '0;
      held_q    <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      rx_cnt_q  <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      tx_cnt_q  <= '0;
      b_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      exp_q     <= exp_d;
      fill_q    <= fill_d;
      rd_idx_q  <= rd_idx_d;
      send_q    <= send_d;
      load_q    <= load_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      tx_cnt_q  <= tx_cnt_d;
      b_valid_q <= go;
      if (b_valid_q) begin
        held_q <= held_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    if (rx_len_we) begin
      rx_len_q[rx_tail_q] <= exp_q;
    end
    if (tx_len_we) begin
      tx_len_q[tx_tail_q] <= tx_len_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= cmd_i.data_byte;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= cmd_i.data_byte;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_raddr];
    end
  end

  always_comb begin
    case (b_q.sel)
      HS_ZERO: held_new = '0;
      HS_LEN:  held_new = b_q.len;
      HS_MEM:  held_new = tx_rdata_q;
      default: held_new = held_q;
    endcase
  end

  assign res_valid_o = b_valid_q;

  always_comb begin
    res_o.bus_byte         = held_new;
    res_o.bus_byte_loaded  = b_q.loaded;
    res_o.host_byte        = b_q.hvalid ? rx_rdata_q : 8'd0;
    res_o.host_byte_valid  = b_q.hvalid;
    res_o.host_byte_last   = b_q.hlast;
    res_o.packet_committed = b_q.committed;
    res_o.status           = b_q.status;
  end

endmodule

// File: hdl/i2c_slave_packet_mailbox.sv
// top level of the i2c slave packet mailbox
// Usage:
// Requests enter through push/full: one bus event or host access per request,
// taken on a rising edge with push high and full low.
// Results leave through empty/pop: the oldest result sits on out_o while
// empty is low and is taken on a rising edge with pop high.
// Every request gives exactly one result, in order.
// An accepted request waits in the request queue; the state update is then
// made together with the registered memory read, after which the result
// enters the result queue. Throughput is one request per cycle while results
// are popped every cycle, set by the three-entry result queue that covers
// the result in flight.
// Receive buffers rotate, so a committed packet is never copied.
// Reset clears all queue pointers, counts and the bus phase; packet memories
// need no clearing pass.
// When the receiver stalls, the result queue fills, the back end holds, and
// full rises once the request queue is full; nothing is lost.
module i2c_slave_packet_mailbox import ispm_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PacketBytesDef,
  parameter int unsigned RX_SLOTS     = RxSlotsDef,
  parameter int unsigned TX_SLOTS     = TxSlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  ispm_in_t  in_i,
  output logic      empty,
  input  logic      pop,
  output ispm_out_t out_o
);

  ispm_cmd_t                     cmd;
  logic                          cmd_valid, cmd_pop, res_valid, out_full;
  ispm_out_t                     res;
  logic [$clog2(OutDepth+1)-1:0] out_level;

  ispm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  ispm_back #(
    .PACKET_BYTES(PACKET_BYTES),
    .RX_SLOTS    (RX_SLOTS),
    .TX_SLOTS    (TX_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_level_i(out_level),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // back end only issues when a slot is reserved, so full never blocks a push
  ispm_fifo #(
    .WIDTH($bits(ispm_out_t)),
    .DEPTH(OutDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid && !out_full),
    .data_i (res),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_o),
    .empty_o(empty),
    .level_o(out_level)
  );

endmodule

// File: tb/tb.sv
// self-checking testbench of the i2c slave packet mailbox
`timescale 1ns / 1ps

module tb;
  import ispm_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  class mailbox_scoreboard;
    logic [7:0]  rx_mem [(RxSlotsDef+1)*PacketBytesDef];
    logic [7:0]  rx_len [RxSlotsDef+1];
    logic [7:0]  tx_mem [TxSlotsDef*PacketBytesDef];
    logic [7:0]  tx_len [TxSlotsDef];
    phase_e      phase = PH_IDLE;
    logic [7:0]  cmd = CMD_LEN, exp_len = '0, fill = '0, rd_idx = '0;
    logic [7:0]  send_idx = '0, load_idx = '0, held = '0;
    int unsigned rx_head = 0, rx_tail = 0, rx_cnt = 0;
    int unsigned tx_head = 0, tx_tail = 0, tx_cnt = 0;
    ispm_out_t   expected_q[$];
    int          errors = 0;
    int          commits = 0, drops = 0, host_bytes = 0, bus_loads = 0, results = 0;

    function bit fits(int unsigned idx);
      return idx < BYTE_LIMIT && idx < PacketBytesDef;
    endfunction

    // works out the result of one accepted request and queues it
    function void note(ispm_in_t req);
      ispm_out_t   r;
      int unsigned stg, len, idx;
      r = '0;
      stg = RxSlotsDef * PacketBytesDef;
      case (req.mode)
        MODE_ADDR: phase = PH_CMD;
        MODE_RX: begin
          if (phase == PH_CMD) begin
            cmd = req.data_byte;
            phase = PH_DATA;
          end else begin
            if (cmd == CMD_LEN) begin
              exp_len = req.data_byte;
              fill = '0;
            end else if (cmd == CMD_DATA) begin
              if (fits(fill)) begin
                rx_mem[stg+fill] = req.data_byte;
                fill++;
              end else r.status = ST_RANGE;
            end
            phase = PH_READ;
          end
        end
        MODE_STOP: begin
          if (phase == PH_READ) begin
            phase = PH_CMD;
            if (fill == exp_len) begin
              fill = '0;
              if (rx_cnt < RxSlotsDef) begin
                for (int i = 0; i < PacketBytesDef; i++)
                  rx_mem[rx_tail*PacketBytesDef+i] = rx_mem[stg+i];
                rx_len[rx_tail] = exp_len;
                rx_tail = (rx_tail + 1) % RxSlotsDef;
                rx_cnt++;
                r.packet_committed = 1'b1;
                commits++;
              end else begin
                r.status = ST_RX_FULL;
                drops++;
              end
            end
          end
        end
        MODE_REQ: begin
          if (phase == PH_DATA) begin
            if (cmd == CMD_LEN || cmd == CMD_DATA) begin
              r.bus_byte_loaded = 1'b1;
              bus_loads++;
              if (tx_cnt == 0) held = '0;
              else if (cmd == CMD_LEN) begin
                send_idx = '0;
                held = tx_len[tx_head];
              end else begin
                len = tx_len[tx_head];
                idx = send_idx;
                held = tx_mem[tx_head*PacketBytesDef+idx];
                if (idx + 1 >= len) begin
                  tx_head = (tx_head + 1) % TxSlotsDef;
                  tx_cnt--;
                  send_idx = '0;
                end else send_idx = 8'(idx + 1);
              end
            end
            phase = PH_CMD;
          end
        end
        MODE_LOAD: begin
          if (tx_cnt >= TxSlotsDef) r.status = ST_TX_FULL;
          else begin
            if (fits(load_idx)) begin
              tx_mem[tx_tail*PacketBytesDef+load_idx] = req.data_byte;
              load_idx++;
            end else r.status = ST_RANGE;
            if (req.last_byte) begin
              tx_len[tx_tail] = load_idx;
              tx_tail = (tx_tail + 1) % TxSlotsDef;
              tx_cnt++;
              load_idx = '0;
            end
          end
        end
        MODE_HOST: begin
          if (rx_cnt == 0) r.status = ST_EMPTY;
          else begin
            len = rx_len[rx_head];
            idx = rd_idx;
            if (len != 0) begin
              r.host_byte = rx_mem[rx_head*PacketBytesDef+idx];
              r.host_byte_valid = 1'b1;
              host_bytes++;
            end
            if (idx + 1 >= len) begin
              r.host_byte_last = 1'b1;
              rx_head = (rx_head + 1) % RxSlotsDef;
              rx_cnt--;
              rd_idx = '0;
            end else rd_idx = 8'(idx + 1);
          end
        end
        default: phase = PH_CMD;
      endcase
      r.bus_byte = held;
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, int unsigned e, int unsigned g);
      if (e != g) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
      end
    endfunction

    function void check(ispm_out_t got);
      ispm_out_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      cmp("bus_byte", e.bus_byte, got.bus_byte);
      cmp("bus_byte_loaded", e.bus_byte_loaded, got.bus_byte_loaded);
      cmp("host_byte", e.host_byte, got.host_byte);
      cmp("host_byte_valid", e.host_byte_valid, got.host_byte_valid);
      cmp("host_byte_last", e.host_byte_last, got.host_byte_last);
      cmp("packet_committed", e.packet_committed, got.packet_committed);
      cmp("status", e.status, got.status);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push, full, empty, pop;
  ispm_in_t  in_i;
  ispm_out_t out_o;

  mailbox_scoreboard sb = new();
  int unsigned idle_pct = 0, stall_pct = 0, cycles = 0, sent = 0;
  bit          hold_req = 1'b0;

  i2c_slave_packet_mailbox dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (in_i),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check(out_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic put(logic [2:0] m, logic [7:0] d, logic l);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= '{mode: m, data_byte: d, last_byte: l};
    do @(posedge clk_i); while (full);
    sb.note('{mode: m, data_byte: d, last_byte: l});
    sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic bus_write(int unsigned n, int unsigned extra);
    put(MODE_ADDR, 8'($urandom), 1'($urandom));
    put(MODE_RX, CMD_LEN, 1'($urandom));
    put(MODE_RX, 8'(n), 1'($urandom));
    put(MODE_STOP, 8'($urandom), 1'($urandom));
    put(MODE_ADDR, 8'($urandom), 1'($urandom));
    put(MODE_RX, CMD_DATA, 1'($urandom));
    repeat (n + extra) put(MODE_RX, 8'($urandom), 1'($urandom));
    put(MODE_STOP, 8'($urandom), 1'($urandom));
  endtask

  task automatic tx_load(int unsigned n);
    for (int i = 0; i < n; i++) put(MODE_LOAD, 8'($urandom), i == n - 1);
  endtask

  task automatic bus_read(logic [7:0] c);
    put(MODE_ADDR, 8'($urandom), 1'($urandom));
    put(MODE_RX, c, 1'($urandom));
    put(MODE_REQ, 8'($urandom), 1'($urandom));
  endtask

  task automatic random_seq();
    int unsigned n, pick;
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
    pick = $urandom_range(99);
    if (pick < 25) bus_write(n, ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
    else if (pick < 45) repeat ($urandom_range(1, 8))
      put(MODE_HOST, 8'($urandom), 1'($urandom));
    else if (pick < 65) tx_load(n + 1);
    else if (pick < 85) repeat ($urandom_range(1, 5))
      bus_read(8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(1)));
    else repeat ($urandom_range(1, 4))
      put(3'($urandom_range(7)), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    int unsigned start;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    put(MODE_HOST, 8'h00, 1'b0);      // host read of an empty queue
    put(MODE_REQ, 8'hff, 1'b1);       // request while idle
    put(MODE_STOP, 8'h00, 1'b0);      // stop outside a transfer
    put(MODE_ADDR, 8'h00, 1'b0);
    put(MODE_RX, CMD_LEN, 1'b0);
    put(MODE_RX, 8'h00, 1'b0);
    put(MODE_STOP, 8'h00, 1'b0);      // zero-length packet commits
    put(MODE_HOST, 8'h00, 1'b0);      // and pops with no byte
    put(MODE_ADDR, 8'h00, 1'b0);
    put(MODE_RX, CMD_DATA, 1'b0);
    put(MODE_RX, 8'hff, 1'b0);
    put(MODE_STOP, 8'h00, 1'b0);      // incomplete packet kept staged
    put(MODE_LOAD, 8'hff, 1'b0);
    put(MODE_LOAD, 8'h00, 1'b1);
    bus_read(CMD_LEN);
    bus_read(CMD_DATA);
    put(MODE_REQ, 8'h00, 1'b0);
    bus_read(8'hf8);                  // unknown command on read
    put(MODE_ERR, 8'h00, 1'b0);
    put(3'd7, 8'hff, 1'b1);
    drain();

    // largest packets: both directions run past the byte limit (receive by one
    // byte, transmit by two) and stay queued for the random phases to read through
    bus_write(255, 1);
    tx_load(257);
    bus_read(CMD_LEN);
    repeat (3) bus_read(CMD_DATA);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 74 : (p == 3) ? 30 : 0;
      stall_pct = (p == 2) ? 74 : (p == 3) ? 30 : 0;
      start = sent;
      if (p == 0) hold_req = 1'b1;
      while (sent - start < 30) random_seq();
      drain();
    end

    push <= 1'b0;
    repeat (20) @(posedge clk_i);
    $display("%0d requests, %0d results; %0d packets committed, %0d dropped",
             sent, sb.results, sb.commits, sb.drops);
    $display("%0d host bytes read, %0d bus bytes loaded, %0d mismatches",
             sb.host_bytes, sb.bus_loads, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
